// ===== sv/light_uart_rx_ber_counter_core_macros.svh =====
// ----------------------------------------------------------------------------
// Light UART receiver BER counter: assertion macros
// Concurrent assertion shorthands shared by the RTL of the block.
// ----------------------------------------------------------------------------
`ifndef LIGHT_UART_RX_BER_COUNTER_CORE_MACROS_SVH
`define LIGHT_UART_RX_BER_COUNTER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LURX_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("light uart rx: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define LURX_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("light uart rx: next-cycle check failed");

`endif

// ===== sv/lurxber_pkg.sv =====
// ----------------------------------------------------------------------------
// Light UART receiver BER counter package
// Types and fixed constants shared by the receiver RTL.
// ----------------------------------------------------------------------------
package lurxber_pkg;

  // Receiver frame phases.
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HALF = 2'd1,
    PH_DATA = 2'd2,
    PH_STOP = 2'd3
  } rx_phase_t;

  // Operation codes carried in tuser of the input stream.
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH    = 2'd2;
  localparam int unsigned CFG_DATA_W = 16;

  // Register widths and reset values.
  localparam int unsigned THR_W = 10;
  localparam int unsigned PER_W = 16;
  localparam int unsigned LEN_W = 5;
  localparam logic [THR_W-1:0] THRESHOLD_RST = 10'd800;
  localparam logic [PER_W-1:0] PERIOD_RST    = 16'd50;
  localparam logic [LEN_W-1:0] LENGTH_RST    = 5'd0;

  // Field widths.
  localparam int unsigned IDX_IN_W = 4;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned OUT_TDATA_W = BYTE_W + 3 * CNT_W;

  localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;
  localparam logic [LEN_W-1:0]  POS_MAX      = 5'd31;
  localparam logic [2:0]        LAST_BIT     = 3'd7;

endpackage

// ===== sv/light_uart_rx_ber_counter_core.sv =====
// ----------------------------------------------------------------------------
// Light UART receiver with bit error counter
// 8N1 receiver on a thresholded light sensor line, comparing received bytes
// with a loaded expected message and keeping saturating error statistics.
// ----------------------------------------------------------------------------
// Usage:
// The in_ stream carries one item per transaction: tuser selects a sample
// tick (0) or a load of one expected message byte (1). tdata holds, from the
// lowest bit up, adc_sample, expected_index and expected_byte.
// The out_ stream carries one result per received frame: tdata holds, from
// the lowest bit up, received_byte, bits_compared, error_bits and
// messages_done; tlast is high when the byte is a newline closing a message.
// The cfg_ port writes the light level threshold (0), bit_period_ticks (1) and
// expected_length (2); it is always ready. The user is to use it only while
// the block idles; the block does not enforce this. Throughput is one input
// item per cycle while in_tready is high: each item is handled by one pass of
// counter, threshold compare and popcount logic into the state registers. The
// result of the tick that ends the stop bit is registered into a two-entry
// output buffer, where results queue; in_tready drops while both entries are
// full, so a stalled receiver holds the input back rather than losing a result.
// Reset restores the register defaults and clears the receiver state and
// counters; the expected message table is undefined until loaded.
// ----------------------------------------------------------------------------
`include "light_uart_rx_ber_counter_core_macros.svh"

module light_uart_rx_ber_counter_core
  import lurxber_pkg::*;
#(
  parameter int unsigned MSG_MAX  = 16,
  parameter int unsigned ADC_BITS = 10
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  // Input stream.
  input  logic                                      in_tvalid,
  output logic                                      in_tready,
  // tdata: adc_sample, expected_index, expected_byte (lowest bit up).
  input  logic [((ADC_BITS+IDX_IN_W+BYTE_W+7)/8)*8-1:0] in_tdata,
  // tuser: operation.
  input  logic                                      in_tuser,
  // Result stream.
  output logic                                      out_tvalid,
  input  logic                                      out_tready,
  // tdata: received_byte, bits_compared, error_bits, messages_done.
  output logic [OUT_TDATA_W-1:0]                    out_tdata,
  // tlast: message_end.
  output logic                                      out_tlast,
  // Configuration write channel.
  input  logic                                      cfg_valid,
  output logic                                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]                      cfg_index,
  input  logic [CFG_DATA_W-1:0]                     cfg_data
);

  localparam int unsigned TBL_DEPTH = (MSG_MAX < 16) ? MSG_MAX : 16;
  localparam int unsigned TBL_IDX_W = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
  localparam int unsigned CMP_W     = (ADC_BITS > THR_W) ? ADC_BITS : THR_W;

  // Configuration registers.
  logic [THR_W-1:0] thr_r;
  logic [PER_W-1:0] per_r;
  logic [LEN_W-1:0] len_r;

  // Receiver state.
  rx_phase_t        phase_r, phase_nxt;
  logic             last_r, last_nxt;
  logic [PER_W-1:0] tc_r, tc_nxt;
  logic [2:0]       bit_r, bit_nxt;
  logic [7:0]       shift_r, shift_nxt;
  logic [LEN_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0] cmp_r, cmp_nxt;
  logic [CNT_W-1:0] err_r, err_nxt;
  logic [CNT_W-1:0] msg_r, msg_nxt;

  logic [BYTE_W-1:0]    tbl_r [TBL_DEPTH];
  logic [BYTE_W-1:0]    tbl_rd_r;
  logic                 tbl_we;
  logic [TBL_IDX_W-1:0] tbl_ra;

  // Output buffer.
  logic                   out_valid_r, skid_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r, skid_data_r;
  logic                   out_last_r, skid_last_r;

  // Input field views.
  logic [ADC_BITS-1:0] in_sample;
  logic [IDX_IN_W-1:0] in_idx;
  logic [BYTE_W-1:0]   in_byte;
  logic                in_acc, tick_acc, load_acc;
  logic                level;

  // Per-item arithmetic.
  logic [PER_W-1:0]  tc_inc;
  logic [3:0]        pop;
  logic [CNT_W:0]    cmp_sum, err_sum, msg_sum;
  logic              can_cmp;

  // Result of this item.
  logic                   res_valid;
  logic                   res_end;
  logic [OUT_TDATA_W-1:0] res_data;
  logic                   out_pop;

  assign in_sample = in_tdata[ADC_BITS-1:0];
  assign in_idx    = in_tdata[ADC_BITS +: IDX_IN_W];
  assign in_byte   = in_tdata[ADC_BITS+IDX_IN_W +: BYTE_W];

  assign in_tready = !skid_valid_r;
  assign in_acc    = in_tvalid && in_tready;
  assign tick_acc  = in_acc && (in_tuser == OP_TICK);
  assign load_acc  = in_acc && (in_tuser == OP_LOAD);
  assign cfg_ready = 1'b1;

  assign level = (CMP_W'(in_sample) > CMP_W'(thr_r));

  // Shared arithmetic for the frame counters and the statistics.
  assign tc_inc  = tc_r + PER_W'(1);
  assign pop     = 4'($countones(shift_r ^ tbl_rd_r));
  assign cmp_sum = {1'b0, cmp_r} + (CNT_W+1)'(8);
  assign err_sum = {1'b0, err_r} + (CNT_W+1)'(pop);
  assign msg_sum = {1'b0, msg_r} + (CNT_W+1)'(1);
  assign can_cmp = (pos_r < len_r) && (32'(pos_r) < MSG_MAX);

  // Next-state logic for one sample tick.
  always_comb begin
    phase_nxt = phase_r;
    last_nxt  = last_r;
    tc_nxt    = tc_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    pos_nxt   = pos_r;
    cmp_nxt   = cmp_r;
    err_nxt   = err_r;
    msg_nxt   = msg_r;
    res_valid = 1'b0;
    res_end   = 1'b0;
    if (tick_acc) begin
      case (phase_r)
        PH_HALF: begin
          tc_nxt = tc_inc;
          if (tc_inc >= (per_r >> 1)) begin
            phase_nxt = PH_DATA;
            tc_nxt    = '0;
          end
        end
        PH_DATA: begin
          tc_nxt = tc_inc;
          if (tc_inc >= per_r) begin
            tc_nxt    = '0;
            shift_nxt = shift_r | (8'(level) << bit_r);
            if (bit_r == LAST_BIT) begin
              bit_nxt   = '0;
              phase_nxt = PH_STOP;
            end else begin
              bit_nxt = bit_r + 3'd1;
            end
          end
        end
        PH_STOP: begin
          tc_nxt = tc_inc;
          if (tc_inc >= per_r) begin
            // Frame complete: account for the byte and rearm.
            res_valid = 1'b1;
            phase_nxt = PH_IDLE;
            tc_nxt    = '0;
            last_nxt  = level;
            if (shift_r != '0) begin
              if (can_cmp) begin
                cmp_nxt = cmp_sum[CNT_W] ? '1 : cmp_sum[CNT_W-1:0];
                err_nxt = err_sum[CNT_W] ? '1 : err_sum[CNT_W-1:0];
              end
              if (pos_r < POS_MAX) begin
                pos_nxt = pos_r + LEN_W'(1);
              end
              if (shift_r == NEWLINE_BYTE) begin
                msg_nxt = msg_sum[CNT_W] ? '1 : msg_sum[CNT_W-1:0];
                pos_nxt = '0;
                res_end = 1'b1;
              end
            end
          end
        end
        default: begin
          // Idle: a falling level starts a frame.
          if (last_r && !level) begin
            phase_nxt = PH_HALF;
            tc_nxt    = '0;
            bit_nxt   = '0;
            shift_nxt = '0;
          end
          last_nxt = level;
        end
      endcase
    end
  end

  // Result payload assembly.
  always_comb begin
    res_data = {msg_nxt, err_nxt, cmp_nxt, shift_r};
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THRESHOLD_RST;
      per_r <= PERIOD_RST;
      len_r <= LENGTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_THRESHOLD: thr_r <= cfg_data[THR_W-1:0];
        CFG_PERIOD:    per_r <= cfg_data[PER_W-1:0];
        CFG_LENGTH:    len_r <= cfg_data[LEN_W-1:0];
        default:       ;
      endcase
    end
  end

  // Receiver state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      last_r  <= 1'b0;
      tc_r    <= '0;
      bit_r   <= '0;
      shift_r <= '0;
      pos_r   <= '0;
      cmp_r   <= '0;
      err_r   <= '0;
      msg_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      last_r  <= last_nxt;
      tc_r    <= tc_nxt;
      bit_r   <= bit_nxt;
      shift_r <= shift_nxt;
      pos_r   <= pos_nxt;
      cmp_r   <= cmp_nxt;
      err_r   <= err_nxt;
      msg_r   <= msg_nxt;
    end
  end

  // Expected message table; loads beyond the table are dropped.
  assign tbl_we = load_acc && (32'(in_idx) < MSG_MAX);
  assign tbl_ra = rst_n ? pos_nxt[TBL_IDX_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_r[in_idx[TBL_IDX_W-1:0]] <= in_byte;
    end
    // Registered read of the entry at the coming message position; a load
    // of that entry in the same cycle is passed straight through.
    if (tbl_we && (in_idx[TBL_IDX_W-1:0] == tbl_ra)) begin
      tbl_rd_r <= in_byte;
    end else begin
      tbl_rd_r <= tbl_r[tbl_ra];
    end
  end

  // Two-entry output buffer: output register plus skid entry.
  assign out_pop = out_valid_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_pop) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_pop) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
        out_last_r <= skid_last_r;
      end else if (res_valid) begin
        out_data_r <= res_data;
        out_last_r <= res_end;
      end
    end else if (res_valid) begin
      skid_data_r <= res_data;
      skid_last_r <= res_end;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // Assertions.
  `LURX_ASSERT_SAME(a_skid_behind_out, skid_valid_r, out_valid_r)
  `LURX_ASSERT_SAME(a_stop_bit_cleared, phase_r == PH_STOP, bit_r == 3'd0)
  `LURX_ASSERT_SAME(a_end_is_newline, out_tvalid && out_tlast,
                    out_tdata[BYTE_W-1:0] == NEWLINE_BYTE)
  `LURX_ASSERT_NEXT(a_load_holds_phase, load_acc, $stable(phase_r) && $stable(tc_r))

endmodule

// ===== tb/sv/light_uart_rx_ber_counter_core_tb.sv =====
// ----------------------------------------------------------------------------
// Light UART receiver BER counter testbench
// Drives thresholded light samples and expected message loads into the
// receiver and checks every result transaction against a cycle-free decoder.
// A short directed table comes first, then random frame traffic over several
// register settings and idling patterns.
// ----------------------------------------------------------------------------
module light_uart_rx_ber_counter_core_tb;
  import lurxber_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD_NS = 4;
  localparam int RESET_CYCLES  = 9;
  localparam int DRAIN_CYCLES  = 8;
  localparam int HOLD_CYCLES   = 600;
  localparam longint TIMEOUT_NS = 2_000_000;

  localparam int ADC_W      = 10;
  localparam int MSG_DEPTH  = 16;
  localparam int IN_TDATA_W = ((ADC_W + IDX_IN_W + BYTE_W + 7) / 8) * 8;

  // One result transaction, laid out as {tlast, tdata}.
  typedef struct packed {
    logic             message_end;
    logic [CNT_W-1:0] messages_done;
    logic [CNT_W-1:0] error_bits;
    logic [CNT_W-1:0] bits_compared;
    logic [BYTE_W-1:0] received_byte;
  } frame_result_t;

  // One row of the directed table; typed rows carry their own result.
  typedef struct packed {
    logic                op;
    logic [ADC_W-1:0]    smp;
    logic [IDX_IN_W-1:0] idx;
    logic [BYTE_W-1:0]   byt;
    logic                typed;
    frame_result_t       res;
  } stim_row_t;

  localparam frame_result_t NO_RESULT = '0;
  // Newline against 8'hFF: six differing bits, one message closed.
  localparam frame_result_t RES_NEWLINE = '{1'b1, 32'd1, 32'd6, 32'd8, NEWLINE_BYTE};
  // Zero byte: reported, but the counters stay where they were.
  localparam frame_result_t RES_ZERO = '{1'b0, 32'd1, 32'd6, 32'd8, 8'h00};

  // Period 1 and reset threshold: every tick after the half wait is a sample.
  localparam int DIR_ROWS = 25;
  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    '{OP_LOAD, 10'd0,    4'd0,  8'hFF, 1'b0, NO_RESULT},
    '{OP_TICK, 10'd1023, 4'd0,  8'h00, 1'b0, NO_RESULT},   // line high
    '{OP_TICK, 10'd800,  4'hF,  8'hFF, 1'b0, NO_RESULT},   // falling edge
    '{OP_TICK, 10'd1023, 4'd0,  8'h00, 1'b0, NO_RESULT},   // half wait, ignored
    '{OP_LOAD, 10'd1023, 4'd15, 8'h00, 1'b0, NO_RESULT},   // load mid-frame
    '{OP_TICK, 10'd0,    4'd0,  8'h00, 1'b0, NO_RESULT},   // data 8'h0A, LSB first
    '{OP_TICK, 10'd801,  4'd0,  8'h00, 1'b0, NO_RESULT},
    '{OP_TICK, 10'd512,  4'd0,  8'h00, 1'b0, NO_RESULT},
    '{OP_TICK, 10'd1023, 4'd0,  8'h00, 1'b0, NO_RESULT},
    '{OP_TICK, 10'd800,  4'd0,  8'h00, 1'b0, NO_RESULT},
    '{OP_TICK, 10'd0,    4'd0,  8'h00, 1'b0, NO_RESULT},
    '{OP_TICK, 10'd100,  4'd0,  8'h00, 1'b0, NO_RESULT},
    '{OP_TICK, 10'd0,    4'd0,  8'h00, 1'b0, NO_RESULT},
    '{OP_TICK, 10'd1023, 4'd0,  8'h00, 1'b1, RES_NEWLINE}, // stop, high rearm
    '{OP_TICK, 10'd0,    4'd0,  8'h00, 1'b0, NO_RESULT},   // edge right after
    '{OP_TICK, 10'd1023, 4'd0,  8'h00, 1'b0, NO_RESULT},   // half wait, ignored
    '{OP_TICK, 10'd0,    4'd0,  8'h00, 1'b0, NO_RESULT},   // data 8'h00
    '{OP_TICK, 10'd800,  4'd0,  8'h00, 1'b0, NO_RESULT},
    '{OP_TICK, 10'd0,    4'd0,  8'h00, 1'b0, NO_RESULT},
    '{OP_TICK, 10'd800,  4'd0,  8'h00, 1'b0, NO_RESULT},
    '{OP_TICK, 10'd0,    4'd0,  8'h00, 1'b0, NO_RESULT},
    '{OP_TICK, 10'd0,    4'd0,  8'h00, 1'b0, NO_RESULT},
    '{OP_TICK, 10'd0,    4'd0,  8'h00, 1'b0, NO_RESULT},
    '{OP_TICK, 10'd0,    4'd0,  8'h00, 1'b0, NO_RESULT},
    '{OP_TICK, 10'd0,    4'd0,  8'h00, 1'b1, RES_ZERO}     // stop, low
  };

  // Random phases: register settings, idling percentages and item budgets.
  localparam int N_PHASES = 8;
  localparam int PH_THR    [N_PHASES] = '{512, 0, 1022, 300, 1023, 600, 100, 700};
  localparam int PH_PER    [N_PHASES] = '{2, 3, 7, 4, 65535, 1, 0, 9};
  localparam int PH_LEN    [N_PHASES] = '{16, 5, 31, 0, 16, 8, 12, 16};
  localparam int PH_GAP    [N_PHASES] = '{0, 58, 0, 10, 58, 0, 10, 0};
  localparam int PH_STALL  [N_PHASES] = '{0, 0, 58, 10, 0, 0, 10, 58};
  localparam int PH_ITEMS  [N_PHASES] = '{300, 250, 250, 250, 40, 250, 200, 410};
  localparam int HOLD_PHASE = 5;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic in_tuser = OP_TICK;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic out_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_THRESHOLD;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Results the decoder has produced and the block still owes.
  frame_result_t frame_results_due [$];
  int fail_count = 0;
  int items_sent = 0;
  int src_gap = 0;
  int sink_stall = 0;
  int hold_req = 0;

  // Decoder state and its copy of the registers.
  logic [THR_W-1:0]   thr_reg = THRESHOLD_RST;
  logic [PER_W-1:0]   per_reg = PERIOD_RST;
  logic [LEN_W-1:0]   len_reg = LENGTH_RST;
  logic               line_was_high = 1'b0;
  rx_phase_t          rx_state = PH_IDLE;
  logic [PER_W-1:0]   tick_cnt = '0;
  logic [2:0]         bit_idx = '0;
  logic [BYTE_W-1:0]  rx_shift = '0;
  logic [LEN_W-1:0]   msg_pos = '0;
  logic [BYTE_W-1:0]  msg_table [MSG_DEPTH];
  logic [CNT_W-1:0]   cmp_count = '0;
  logic [CNT_W-1:0]   err_count = '0;
  logic [CNT_W-1:0]   msg_count = '0;

  light_uart_rx_ber_counter_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #(CLK_PERIOD_NS / 2) clk = ~clk;

  // Saturating addition for the running statistics.
  function automatic logic [CNT_W-1:0] counter_add_sat(input logic [CNT_W-1:0] acc,
                                                       input logic [CNT_W-1:0] inc);
    logic [CNT_W:0] sum;
    sum = {1'b0, acc} + {1'b0, inc};
    counter_add_sat = sum[CNT_W] ? '1 : sum[CNT_W-1:0];
  endfunction

  // An idle tick: a high-to-low change of level opens a frame.
  task automatic watch_for_start(input logic lv);
    if (line_was_high && !lv) begin
      rx_state = PH_HALF;
      tick_cnt = '0;
      bit_idx  = '0;
      rx_shift = '0;
    end
    line_was_high = lv;
  endtask

  // Decodes one accepted input item and reports the result it causes.
  task automatic decode_item(input logic op, input logic [ADC_W-1:0] smp,
                             input logic [IDX_IN_W-1:0] idx, input logic [BYTE_W-1:0] byt,
                             output logic have, output frame_result_t res);
    logic lv;
    logic closes;
    have = 1'b0;
    res = NO_RESULT;
    closes = 1'b0;
    lv = (smp > thr_reg);
    if (op == OP_LOAD) begin
      msg_table[idx] = byt;
    end else begin
      case (rx_state)
        PH_HALF: begin
          tick_cnt = tick_cnt + 1'b1;
          if (tick_cnt >= (per_reg >> 1)) begin
            rx_state = PH_DATA;
            tick_cnt = '0;
          end
        end
        PH_DATA: begin
          tick_cnt = tick_cnt + 1'b1;
          if (tick_cnt >= per_reg) begin
            tick_cnt = '0;
            rx_shift[bit_idx] = rx_shift[bit_idx] | lv;
            if (bit_idx == LAST_BIT) begin
              bit_idx = '0;
              rx_state = PH_STOP;
            end else begin
              bit_idx = bit_idx + 1'b1;
            end
          end
        end
        PH_STOP: begin
          tick_cnt = tick_cnt + 1'b1;
          if (tick_cnt >= per_reg) begin
            // A zero byte is reported but neither compared nor counted.
            if (rx_shift != '0) begin
              if (msg_pos < len_reg && msg_pos < MSG_DEPTH) begin
                cmp_count = counter_add_sat(cmp_count, 32'd8);
                err_count = counter_add_sat(err_count,
                                            $countones(rx_shift ^ msg_table[msg_pos[3:0]]));
              end
              if (msg_pos < POS_MAX) msg_pos = msg_pos + 1'b1;
              if (rx_shift == NEWLINE_BYTE) begin
                msg_count = counter_add_sat(msg_count, 32'd1);
                msg_pos = '0;
                closes = 1'b1;
              end
            end
            res = '{closes, msg_count, err_count, cmp_count, rx_shift};
            have = 1'b1;
            rx_state = PH_IDLE;
            tick_cnt = '0;
            // The ending tick rearms from low, so it cannot itself be an edge.
            line_was_high = 1'b0;
            watch_for_start(lv);
          end
        end
        default: watch_for_start(lv);
      endcase
    end
  endtask

  // Offers one input transaction, waits for acceptance and records the result.
  task automatic send_item(input logic op, input logic [ADC_W-1:0] smp,
                           input logic [IDX_IN_W-1:0] idx, input logic [BYTE_W-1:0] byt,
                           input logic typed, input frame_result_t typed_res);
    logic have;
    frame_result_t res;
    logic [IN_TDATA_W-1:0] word;
    while ($urandom_range(0, 99) < src_gap) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    word = '0;
    word[ADC_W-1:0] = smp;
    word[ADC_W +: IDX_IN_W] = idx;
    word[ADC_W+IDX_IN_W +: BYTE_W] = byt;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= word;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    decode_item(op, smp, idx, byt, have, res);
    if (typed) frame_results_due.push_back(typed_res);
    else if (have) frame_results_due.push_back(res);
  endtask

  // A sample tick whose reading lies on the wanted side of the threshold.
  task automatic send_level(input logic lv);
    int unsigned thr_i;
    logic [31:0] r;
    thr_i = 32'(thr_reg);
    r = $urandom;
    if (!lv) r[ADC_W-1:0] = ADC_W'($urandom_range(thr_i, 0));
    else if (thr_i < 1023) r[ADC_W-1:0] = ADC_W'($urandom_range(1023, thr_i + 1));
    send_item(OP_TICK, r[ADC_W-1:0], r[13:10], r[21:14], 1'b0, NO_RESULT);
  endtask

  // Loads one random table entry.
  task automatic send_load();
    logic [31:0] r;
    r = $urandom;
    send_item(OP_LOAD, r[ADC_W-1:0], r[13:10], r[21:14], 1'b0, NO_RESULT);
  endtask

  // A short burst of loads and ticks with arbitrary readings.
  task automatic send_noise();
    logic [31:0] r;
    repeat ($urandom_range(1, 4)) begin
      r = $urandom;
      if ($urandom_range(0, 9) < 3) send_load();
      else send_item(OP_TICK, r[ADC_W-1:0], r[13:10], r[21:14], 1'b0, NO_RESULT);
    end
  endtask

  // Byte for the next frame, mostly following the expected message.
  function automatic logic [BYTE_W-1:0] pick_byte();
    int unsigned r;
    logic [BYTE_W-1:0] b;
    r = $urandom_range(0, 99);
    b = BYTE_W'($urandom_range(0, 255));
    if (r < 45) begin
      b = msg_table[msg_pos[3:0]];
      if ($urandom_range(0, 2) == 0) b[$urandom_range(0, 7)] ^= 1'b1;
    end else if (r < 60) begin
      b = NEWLINE_BYTE;
    end else if (r < 68) begin
      b = '0;
    end
    pick_byte = b;
  endfunction

  // One 8N1 frame timed to the current period. Ticks that the receiver
  // samples carry the wanted bit; the others follow the nominal waveform
  // with occasional glitches. A truncated frame stops half way through.
  task automatic send_frame(input logic [BYTE_W-1:0] data, input bit truncate);
    int unsigned half_w, bit_w, span, stop_at, t, k;
    logic lv;
    half_w = ((per_reg >> 1) == 0) ? 1 : 32'(per_reg >> 1);
    bit_w  = (per_reg < 2) ? 1 : 32'(per_reg);
    span   = half_w + 9 * bit_w;
    stop_at = truncate ? span / 2 : span;
    repeat ($urandom_range(1, 3)) send_level(1'b1);
    for (t = 0; t <= stop_at; t++) begin
      if (t == 0) begin
        lv = 1'b0;
      end else if (t == span) begin
        lv = ($urandom_range(0, 9) != 0);
      end else if (t >= half_w + bit_w && (t - half_w) % bit_w == 0) begin
        lv = data[(t - half_w) / bit_w - 1];
      end else begin
        k = t / bit_w;
        lv = (k == 0) ? 1'b0 : (k >= 9) ? 1'b1 : data[k-1];
        if ($urandom_range(0, 19) == 0) lv = ~lv;
      end
      if ($urandom_range(0, 49) == 0) send_load();
      send_level(lv);
    end
  endtask

  // Writes one register and mirrors it in the decoder.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_THRESHOLD: thr_reg = val[THR_W-1:0];
      CFG_PERIOD:    per_reg = val[PER_W-1:0];
      CFG_LENGTH:    len_reg = val[LEN_W-1:0];
      default: ;
    endcase
  endtask

  // Lets every owed result arrive and the pipeline empty.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (frame_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  always @(posedge clk) begin : result_sink
    int hold_left;
    int hold_seen;
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= sink_stall);
    end
  end

  // Each result transaction against the oldest owed result.
  always @(posedge clk) begin : result_check
    frame_result_t got;
    frame_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tlast, out_tdata};
      if (frame_results_due.size() == 0) begin
        $error("unexpected result transaction: received_byte %0h", got.received_byte);
        fail_count++;
      end else begin
        want = frame_results_due.pop_front();
        if (got.received_byte !== want.received_byte) begin
          $error("received_byte: expected %0h, actual %0h",
                 want.received_byte, got.received_byte);
          fail_count++;
        end
        if (got.message_end !== want.message_end) begin
          $error("message_end: expected %0b, actual %0b", want.message_end, got.message_end);
          fail_count++;
        end
        if (got.bits_compared !== want.bits_compared) begin
          $error("bits_compared: expected %0d, actual %0d",
                 want.bits_compared, got.bits_compared);
          fail_count++;
        end
        if (got.error_bits !== want.error_bits) begin
          $error("error_bits: expected %0d, actual %0d", want.error_bits, got.error_bits);
          fail_count++;
        end
        if (got.messages_done !== want.messages_done) begin
          $error("messages_done: expected %0d, actual %0d",
                 want.messages_done, got.messages_done);
          fail_count++;
        end
      end
    end
  end

  // Main sequence: reset, directed table, random phases, final verdict.
  initial begin : stimulus
    int ph;
    int row;
    int start;
    int e;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part runs at the reset threshold with the shortest waits.
    write_reg(CFG_PERIOD, 16'd1);
    write_reg(CFG_LENGTH, 16'd1);
    cfg_valid <= 1'b0;
    for (row = 0; row < DIR_ROWS; row++) begin
      send_item(DIRECTED[row].op, DIRECTED[row].smp, DIRECTED[row].idx,
                DIRECTED[row].byt, DIRECTED[row].typed, DIRECTED[row].res);
    end

    for (ph = 0; ph < N_PHASES; ph++) begin
      settle();
      write_reg(CFG_THRESHOLD, CFG_DATA_W'(PH_THR[ph]));
      write_reg(CFG_PERIOD, CFG_DATA_W'(PH_PER[ph]));
      write_reg(CFG_LENGTH, CFG_DATA_W'(PH_LEN[ph]));
      cfg_valid <= 1'b0;
      src_gap = PH_GAP[ph];
      sink_stall = PH_STALL[ph];
      if (ph == HOLD_PHASE) hold_req++;
      // Fill the whole table before anything can be compared against it.
      if (ph == 0) begin
        for (e = 0; e < MSG_DEPTH; e++) begin
          send_item(OP_LOAD, ADC_W'($urandom_range(0, 1023)), IDX_IN_W'(e),
                    BYTE_W'($urandom_range(0, 255)), 1'b0, NO_RESULT);
        end
      end
      start = items_sent;
      while (items_sent - start < PH_ITEMS[ph]) begin
        if (per_reg > 1000 || $urandom_range(0, 9) == 0) send_noise();
        else send_frame(pick_byte(), $urandom_range(0, 19) == 0);
      end
      // Close any open frame and leave the line low, so that the next
      // settings cannot see a falling edge on their first tick.
      while (rx_state != PH_IDLE || line_was_high) send_level(1'b0);
    end

    settle();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog for a run that stops making progress.
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
